// ===== design/ipv6t_pkg.sv =====
// Shared types and constants for the IPv6 text-to-binary parser.
// No dependencies; every other design file imports this package.
package ipv6t_pkg;

	localparam int GROUP_W = 16;
	localparam int GROUPS = 8;
	localparam int GROUP_IDX_W = $clog2(GROUPS);
	localparam int ADDR_W = GROUP_W * GROUPS;
	localparam int HALF_W = ADDR_W / 2;

	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);

	localparam logic [2:0] MAX_DIGITS = 3'd4;
	localparam logic [3:0] GROUP_LIMIT = 4'd8;
	localparam logic [3:0] GAP_GROUP_LIMIT = 4'd7;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] LOWER_BIAS = 8'h57;
	localparam logic [7:0] UPPER_BIAS = 8'h37;

	typedef enum logic [1:0] {
		KIND_HEX,
		KIND_COLON,
		KIND_BAD
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_BAD_CHAR,
		STAT_LONG_GROUP,
		STAT_BAD_COUNT
	} status_t;

	typedef struct packed {
		kind_t kind;
		logic [3:0] value;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic [HALF_W-1:0] addr_high;
		logic [HALF_W-1:0] addr_low;
		status_t status;
	} result_t;

endpackage

// ===== design/ipv6t_front.sv =====
// Front end of the IPv6 text parser: classifies each character and queues it.
// Depends on ipv6t_pkg.
module ipv6t_front (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] char_code,
	input  logic is_last,
	input  logic push,
	output logic full,
	output ipv6t_pkg::cmd_t cmd,
	output logic cmd_valid,
	input  logic cmd_take
);
	import ipv6t_pkg::*;

	cmd_t in_cmd;
	cmd_t mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_q;
	logic [CMD_PTR_W-1:0] rd_q;
	logic [CMD_PTR_W:0] cnt_q;
	logic do_push;
	logic do_pop;

	always_comb begin
		in_cmd.last = is_last;
		in_cmd.value = 4'd0;
		priority if (char_code == CHAR_COLON) begin
			in_cmd.kind = KIND_COLON;
		end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
			in_cmd.kind = KIND_HEX;
			in_cmd.value = char_code[3:0];
		end else if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_F) begin
			in_cmd.kind = KIND_HEX;
			in_cmd.value = 4'(char_code - LOWER_BIAS);
		end else if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_F) begin
			in_cmd.kind = KIND_HEX;
			in_cmd.value = 4'(char_code - UPPER_BIAS);
		end else begin
			in_cmd.kind = KIND_BAD;
		end
	end

	assign full = (cnt_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + CMD_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + CMD_PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + (CMD_PTR_W+1)'(1);
				2'b01: cnt_q <= cnt_q - (CMD_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/ipv6t_back.sv =====
// Back end of the IPv6 text parser: group accumulation, "::" expansion,
// checks, and the result queue. Depends on ipv6t_pkg.
module ipv6t_back (
	input  logic clk,
	input  logic arst_n,
	input  ipv6t_pkg::cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_take,
	output logic [ipv6t_pkg::HALF_W-1:0] addr_high,
	output logic [ipv6t_pkg::HALF_W-1:0] addr_low,
	output logic [1:0] status,
	output logic empty,
	input  logic pop
);
	import ipv6t_pkg::*;

	logic [GROUP_W-1:0] accum_q;
	logic [2:0] digits_q;
	logic [3:0] gcount_q;
	logic [3:0] gap_pos_q;
	logic gap_seen_q;
	logic colon_q;
	status_t err_q;
	logic [GROUP_W-1:0] head_q [GROUPS];
	logic [ADDR_W-1:0] tail_q;

	logic [GROUP_W-1:0] nx_accum;
	logic [2:0] nx_digits;
	logic [3:0] nx_gcount;
	logic [3:0] nx_gap_pos;
	logic nx_gap_seen;
	logic nx_colon;
	status_t nx_err;
	logic [GROUP_W-1:0] nx_head [GROUPS];
	logic [ADDR_W-1:0] nx_tail;
	logic [ADDR_W-1:0] full_addr;
	logic push_req;
	result_t res;

	result_t res_mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] res_wr_q;
	logic [RES_PTR_W-1:0] res_rd_q;
	logic [RES_PTR_W:0] res_cnt_q;
	logic res_full;
	logic res_push;
	logic res_pop;

	always_comb begin
		nx_accum = accum_q;
		nx_digits = digits_q;
		nx_gcount = gcount_q;
		nx_gap_pos = gap_pos_q;
		nx_gap_seen = gap_seen_q;
		nx_colon = colon_q;
		nx_err = err_q;
		nx_head = head_q;
		nx_tail = tail_q;
		push_req = 1'b0;
		full_addr = '0;

		if (nx_err == STAT_OK) begin
			unique case (cmd.kind)
				KIND_COLON: begin
					if (nx_digits != 3'd0) begin
						push_req = 1'b1;
					end else if (nx_colon) begin
						if (nx_gap_seen) begin
							nx_err = STAT_BAD_COUNT;
						end else begin
							nx_gap_seen = 1'b1;
							nx_gap_pos = nx_gcount;
						end
					end
					nx_colon = 1'b1;
				end
				KIND_HEX: begin
					priority if (nx_colon && nx_gcount == 4'd0 && !nx_gap_seen) begin
						nx_err = STAT_BAD_COUNT;
					end else if (nx_digits >= MAX_DIGITS) begin
						nx_err = STAT_LONG_GROUP;
					end else begin
						nx_accum = {nx_accum[GROUP_W-5:0], cmd.value};
						nx_digits = nx_digits + 3'd1;
						nx_colon = 1'b0;
					end
				end
				default: nx_err = STAT_BAD_CHAR;
			endcase
		end

		// Groups before the "::" land at their own slot; later groups shift
		// into the tail, which leaves them right-aligned for the expansion.
		if (push_req || (cmd.last && nx_err == STAT_OK && nx_digits != 3'd0)) begin
			if (nx_gcount >= GROUP_LIMIT) begin
				nx_err = STAT_BAD_COUNT;
			end else begin
				if (nx_gap_seen) begin
					nx_tail = {nx_tail[ADDR_W-GROUP_W-1:0], nx_accum};
				end else begin
					nx_head[nx_gcount[GROUP_IDX_W-1:0]] = nx_accum;
				end
				nx_gcount = nx_gcount + 4'd1;
			end
			nx_accum = '0;
			nx_digits = 3'd0;
		end

		if (cmd.last) begin
			if (nx_err == STAT_OK && nx_colon &&
			    !(nx_gap_seen && nx_gap_pos == nx_gcount)) begin
				nx_err = STAT_BAD_COUNT;
			end
			if (nx_err == STAT_OK &&
			    (nx_gap_seen ? (nx_gcount > GAP_GROUP_LIMIT) : (nx_gcount != GROUP_LIMIT))) begin
				nx_err = STAT_BAD_COUNT;
			end
			for (int i = 0; i < GROUPS; i++) begin
				full_addr[ADDR_W-1-GROUP_W*i -: GROUP_W] = nx_head[i];
			end
			full_addr = full_addr | nx_tail;
			if (nx_err != STAT_OK) begin
				full_addr = '0;
			end
		end

		res.addr_high = full_addr[ADDR_W-1:HALF_W];
		res.addr_low = full_addr[HALF_W-1:0];
		res.status = nx_err;
	end

	assign res_full = (res_cnt_q == (RES_PTR_W+1)'(RES_DEPTH));
	assign cmd_take = cmd_valid && !(cmd.last && res_full);
	assign res_push = cmd_take && cmd.last;
	assign empty = (res_cnt_q == '0);
	assign res_pop = pop && !empty;
	assign addr_high = res_mem_q[res_rd_q].addr_high;
	assign addr_low = res_mem_q[res_rd_q].addr_low;
	assign status = res_mem_q[res_rd_q].status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			digits_q <= '0;
			gcount_q <= '0;
			gap_pos_q <= '0;
			gap_seen_q <= 1'b0;
			colon_q <= 1'b0;
			err_q <= STAT_OK;
			tail_q <= '0;
			for (int i = 0; i < GROUPS; i++) begin
				head_q[i] <= '0;
			end
		end else if (cmd_take) begin
			if (cmd.last) begin
				accum_q <= '0;
				digits_q <= '0;
				gcount_q <= '0;
				gap_pos_q <= '0;
				gap_seen_q <= 1'b0;
				colon_q <= 1'b0;
				err_q <= STAT_OK;
				tail_q <= '0;
				for (int i = 0; i < GROUPS; i++) begin
					head_q[i] <= '0;
				end
			end else begin
				accum_q <= nx_accum;
				digits_q <= nx_digits;
				gcount_q <= nx_gcount;
				gap_pos_q <= nx_gap_pos;
				gap_seen_q <= nx_gap_seen;
				colon_q <= nx_colon;
				err_q <= nx_err;
				tail_q <= nx_tail;
				head_q <= nx_head;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q <= '0;
			res_rd_q <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= res_wr_q + RES_PTR_W'(1);
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + RES_PTR_W'(1);
			end
			unique case ({res_push, res_pop})
				2'b10: res_cnt_q <= res_cnt_q + (RES_PTR_W+1)'(1);
				2'b01: res_cnt_q <= res_cnt_q - (RES_PTR_W+1)'(1);
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

endmodule

// ===== design/ipv6_text_to_binary.sv =====
// Top level of the IPv6 text-to-binary parser.
// Depends on ipv6t_pkg, ipv6t_front and ipv6t_back.
//
// Push the characters of one IPv6 address in colon-hexadecimal text, one
// word per cycle, with is_last set on the final character. When that
// character has been taken, one result word appears on the output queue
// holding the full 128-bit address in addr_high and addr_low and a status
// code: zero means the text was well formed, and any other code means the
// address fields read zero. The block takes one character every cycle while
// full is low; the result of an address is registered in the result queue
// once the back end takes its last character, since each character is first
// registered in the classifier queue and the group update in the back end is
// combinational. Characters keep flowing while fewer than two results wait to
// be popped; with two waiting, the last character of an address is held.
module ipv6_text_to_binary (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] char_code,
	input  logic is_last,
	input  logic push,
	output logic full,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low,
	output logic [1:0] status,
	output logic empty,
	input  logic pop
);
	import ipv6t_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;

	ipv6t_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.char_code(char_code),
		.is_last(is_last),
		.push(push),
		.full(full),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take)
	);

	ipv6t_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.addr_high(addr_high),
		.addr_low(addr_low),
		.status(status),
		.empty(empty),
		.pop(pop)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("Back end took a character from an empty queue.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != STAT_OK) |-> (addr_high == '0 && addr_low == '0))
		else $error("A failed parse carries a nonzero address.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd.last && empty) |=> !empty)
		else $error("Last character did not produce a result.");

endmodule

// ===== bench/ipv6t_bench_pkg.sv =====
// Address tracker for the IPv6 text-to-binary bench: it predicts each address
// from the characters the block takes and checks every result word against it.
// Depends on ipv6t_pkg.
package ipv6t_bench_pkg;
	import ipv6t_pkg::*;

	class addr_tracker;
		result_t expected_addrs[$];
		int unsigned mismatches;

		logic [GROUP_W-1:0] groups_done[GROUPS];
		logic [GROUP_W-1:0] accum;
		logic [2:0] digits;
		logic [3:0] group_cnt;
		logic [3:0] gap_at;
		bit gap_seen;
		bit prev_colon;
		status_t fault;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			foreach (groups_done[i]) groups_done[i] = '0;
			accum = '0;
			digits = '0;
			group_cnt = '0;
			gap_at = '0;
			gap_seen = 1'b0;
			prev_colon = 1'b0;
			fault = STAT_OK;
		endfunction

		function int unsigned waiting();
			return expected_addrs.size();
		endfunction

		function void flag(status_t code);
			if (fault == STAT_OK) begin
				fault = code;
			end
		endfunction

		function void close_group();
			if (group_cnt >= GROUP_LIMIT) begin
				flag(STAT_BAD_COUNT);
			end else begin
				groups_done[group_cnt[GROUP_IDX_W-1:0]] = accum;
				group_cnt++;
			end
			accum = '0;
			digits = '0;
		endfunction

		function void take_char(logic [7:0] c);
			logic [3:0] nib;
			bit hex;
			hex = 1'b1;
			nib = '0;
			if (c == CHAR_COLON) begin
				if (digits != 0) begin
					close_group();
				end else if (prev_colon) begin
					if (gap_seen) begin
						flag(STAT_BAD_COUNT);
					end else begin
						gap_seen = 1'b1;
						gap_at = group_cnt;
					end
				end
				prev_colon = 1'b1;
				return;
			end
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				nib = 4'(c - CHAR_ZERO);
			end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
				nib = 4'(c - CHAR_LOWER_A + 8'd10);
			end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
				nib = 4'(c - CHAR_UPPER_A + 8'd10);
			end else begin
				hex = 1'b0;
			end
			if (!hex) begin
				flag(STAT_BAD_CHAR);
				return;
			end
			if (prev_colon && group_cnt == 0 && !gap_seen) begin
				flag(STAT_BAD_COUNT);
				return;
			end
			if (digits >= MAX_DIGITS) begin
				flag(STAT_LONG_GROUP);
				return;
			end
			accum = {accum[GROUP_W-5:0], nib};
			digits++;
			prev_colon = 1'b0;
		endfunction

		// Called for every accepted input word; the final character of an
		// address closes the text and queues the address it should yield.
		function void note_char(logic [7:0] c, logic last);
			logic [GROUP_W-1:0] spread[GROUPS];
			result_t addr;
			int dest;
			if (fault == STAT_OK) begin
				take_char(c);
			end
			if (!last) begin
				return;
			end
			if (fault == STAT_OK && digits != 0) begin
				close_group();
			end
			if (fault == STAT_OK && prev_colon && !(gap_seen && gap_at == group_cnt)) begin
				flag(STAT_BAD_COUNT);
			end
			if (fault == STAT_OK) begin
				if (gap_seen ? group_cnt > GAP_GROUP_LIMIT : group_cnt != GROUP_LIMIT) begin
					flag(STAT_BAD_COUNT);
				end
			end
			foreach (spread[i]) spread[i] = '0;
			if (fault == STAT_OK) begin
				for (int i = 0; i < group_cnt; i++) begin
					dest = i;
					if (gap_seen && i >= gap_at) begin
						dest = i + GROUPS - group_cnt;
					end
					spread[dest] = groups_done[i];
				end
			end
			addr.addr_high = {spread[0], spread[1], spread[2], spread[3]};
			addr.addr_low = {spread[4], spread[5], spread[6], spread[7]};
			addr.status = fault;
			expected_addrs.insert(expected_addrs.size(), addr);
			clear();
		endfunction

		function void check_addr(logic [HALF_W-1:0] high, logic [HALF_W-1:0] low,
				logic [1:0] stat);
			result_t want;
			if (expected_addrs.size() == 0) begin
				$display("%0t unexpected result word: addr_high %h addr_low %h status %0d",
					$time, high, low, stat);
				mismatches++;
				return;
			end
			want = expected_addrs.pop_front();
			if (high !== want.addr_high) begin
				$display("%0t addr_high expected %h actual %h", $time, want.addr_high, high);
				mismatches++;
			end
			if (low !== want.addr_low) begin
				$display("%0t addr_low expected %h actual %h", $time, want.addr_low, low);
				mismatches++;
			end
			if (stat !== want.status) begin
				$display("%0t status expected %0d actual %0d", $time, want.status, stat);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== bench/testbench.sv =====
// Top-level bench for ipv6_text_to_binary: drives address texts, one character
// per word, and checks each result word. Depends on ipv6t_pkg and ipv6t_bench_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ipv6t_pkg::*;
	import ipv6t_bench_pkg::*;

	localparam int unsigned STIM_CHARS = 1135;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef logic [7:0] text_q[$];
	typedef enum {FLIP_CHAR, EXTRA_DIGIT, EXTRA_COLON, DROP_CHAR, EXTRA_GROUP} flaw_t;

	logic clk;
	logic arst_n;
	logic [7:0] char_code;
	logic is_last;
	logic push;
	logic full;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	logic [1:0] status;
	logic empty;
	logic pop;

	addr_tracker book;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int unsigned sent = 0;
	int unsigned cycle_cnt = 0;

	ipv6_text_to_binary u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_code(char_code),
		.is_last(is_last),
		.push(push),
		.full(full),
		.addr_high(addr_high),
		.addr_low(addr_low),
		.status(status),
		.empty(empty),
		.pop(pop)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic bit take_gap();
		return !no_idle && $urandom_range(99) < 21;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 10) begin
			return CHAR_ZERO + n;
		end else if ($urandom_range(1) != 0) begin
			return CHAR_LOWER_A + n - 8'd10;
		end else begin
			return CHAR_UPPER_A + n - 8'd10;
		end
	endfunction

	function automatic text_q from_string(string s);
		text_q t;
		for (int i = 0; i < s.len(); i++) begin
			t.insert(t.size(), s[i]);
		end
		return t;
	endfunction

	// Mostly well-formed addresses with random content, some with one flaw,
	// and a share of raw byte noise.
	function automatic text_q make_text();
		text_q t;
		int unsigned kind;
		int unsigned n;
		int unsigned gap;
		int unsigned len;
		int unsigned pos;
		bit squeeze;
		kind = $urandom_range(99);
		if (kind >= 85) begin
			len = $urandom_range(6, 1);
			repeat (len) t.insert(t.size(), 8'($urandom_range(255)));
			return t;
		end
		squeeze = $urandom_range(1);
		n = squeeze ? $urandom_range(GAP_GROUP_LIMIT) : GROUPS;
		gap = $urandom_range(n);
		for (int i = 0; i < n; i++) begin
			if (squeeze && i == gap) begin
				t.insert(t.size(), CHAR_COLON);
				t.insert(t.size(), CHAR_COLON);
			end else if (i > 0) begin
				t.insert(t.size(), CHAR_COLON);
			end
			len = $urandom_range(MAX_DIGITS, 1);
			repeat (len) t.insert(t.size(), hex_char(4'($urandom_range(15))));
		end
		if (squeeze && gap == n) begin
			t.insert(t.size(), CHAR_COLON);
			t.insert(t.size(), CHAR_COLON);
		end
		if (kind >= 65) begin
			pos = $urandom_range(t.size() - 1);
			case (flaw_t'($urandom_range(4)))
				FLIP_CHAR: t[pos] = 8'($urandom_range(255));
				EXTRA_DIGIT: t.insert(pos, hex_char(4'($urandom_range(15))));
				EXTRA_COLON: t.insert(pos, CHAR_COLON);
				DROP_CHAR: begin
					if (t.size() > 1) begin
						t.delete(pos);
					end
				end
				default: begin
					t.insert(t.size(), CHAR_COLON);
					t.insert(t.size(), hex_char(4'($urandom_range(15))));
				end
			endcase
		end
		return t;
	endfunction

	task automatic send_char(logic [7:0] c, logic last);
		@(negedge clk);
		while (take_gap()) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		char_code <= c;
		is_last <= last;
		@(posedge clk);
		while (full !== 1'b0) @(posedge clk);
		book.note_char(c, last);
		sent++;
	endtask

	task automatic send_text(text_q t);
		for (int i = 0; i < t.size(); i++) begin
			send_char(t[i], i == t.size() - 1);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (book.waiting() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned hold_left;
		pop = 1'b0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= !take_gap();
			end
			@(posedge clk);
			if (pop && empty === 1'b0) begin
				book.check_addr(addr_high, addr_low, status);
			end
		end
	end

	initial begin
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		book = new();
		arst_n = 1'b0;
		push = 1'b0;
		char_code = '0;
		is_last = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_text(from_string("::"));
		send_text(from_string("::1"));
		send_text(from_string("1::"));
		send_text(from_string(":1"));
		send_text(from_string("1:"));
		send_text(from_string("12345"));
		send_text(from_string(":::"));
		send_text(from_string("0"));
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);

		while (sent < STIM_CHARS) begin
			no_idle = sent >= 400 && sent < 650;
			if (!held && sent >= 700) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && sent >= 900) begin
				paused = 1'b1;
				drain_results();
			end
			send_text(make_text());
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.mismatches == 0 && book.waiting() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
